>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/mibqm_pkg.sv
// ----------------------------------------------------------------------------
// mibqm_pkg
// Sizes, codes and control types of the queue manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mibqm_pkg;

  localparam int CONNECTIONS  = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int POOL_BUFFERS = 16;

  localparam int CONN_W   = 3;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W   = CONN_W + PTR_W;
  localparam int STORE_D  = CONNECTIONS * QUEUE_DEPTH;
  localparam int POOL_W   = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1;
  localparam int HANDLE_W = 8;
  localparam int ALLOC_W  = 5;
  localparam int CNT_W    = 4;

  typedef enum logic [2:0] {
    ACT_OPEN  = 3'd0,
    ACT_CLOSE = 3'd1,
    ACT_ENQ   = 3'd2,
    ACT_DEQ   = 3'd3,
    ACT_ALLOC = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CONN   = 3'd1,
    ST_FULL       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NULL       = 3'd4,
    ST_POOL_OUT   = 3'd5,
    ST_FREED_NONE = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

>>> rtl/core/mibqm_ram.sv
// ----------------------------------------------------------------------------
// mibqm_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mibqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mibqm_ctrl.sv
// ----------------------------------------------------------------------------
// mibqm_ctrl
// Command sequencer: accept an item, run it, strobe the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mibqm_ctrl
  import mibqm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

  `ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o, "accepted item not run")
  `ASSERT_NEXT(a_exec_done, cmd_o.exec, done_o && !busy_o, "result strobe missing after run")
  `ASSERT_IMPL(a_done_single, done_o, !$past(done_o), "result strobe longer than one cycle")

endmodule

>>> rtl/core/mibqm_dp.sv
// ----------------------------------------------------------------------------
// mibqm_dp
// Queue pointers, connection flags, buffer pool, queue store and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mibqm_dp
  import mibqm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [2:0]          action_i,
  input  logic [CONN_W-1:0]   instance_req_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic [2:0]          status_o,
  output logic [ALLOC_W-1:0]  alloc_handle_o,
  output logic                indicator_write_o,
  output logic                indicator_value_o,
  output logic [CNT_W-1:0]    free_instance_o,
  output logic [CNT_W-1:0]    active_count_o
);

  action_e             act_q;
  logic [CONN_W-1:0]   conn_q;
  logic [HANDLE_W-1:0] hdl_q;

  logic [PTR_W-1:0]        rd_ptr_q [CONNECTIONS];
  logic [PTR_W-1:0]        wr_ptr_q [CONNECTIONS];
  logic [PTR_W-1:0]        rd_ptr_d [CONNECTIONS];
  logic [PTR_W-1:0]        wr_ptr_d [CONNECTIONS];
  logic [CONNECTIONS-1:0]  active_q, active_d;
  logic [CNT_W-1:0]        act_cnt_q, act_cnt_d;
  logic [POOL_BUFFERS-1:0] pool_q, pool_d;

  status_e            status_q, status_d;
  logic [ALLOC_W-1:0] alloc_q, alloc_d;
  logic               iw_q, iw_d, iv_q, iv_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [CNT_W-1:0]   cnt_q;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [HANDLE_W-1:0] rdata;

  logic             conn_on;
  logic [PTR_W-1:0] rp, wp, rp_nx, wp_nx;
  logic [POOL_W-1:0] pool_slot;
  logic              pool_hit;

  mibqm_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(STORE_D)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(hdl_q),
    .re_i   (cmd_i.load),
    .raddr_i({instance_req_i, rd_ptr_q[instance_req_i]}),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      conn_q <= instance_req_i;
      hdl_q  <= handle_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      alloc_q  <= alloc_d;
      iw_q     <= iw_d;
      iv_q     <= iv_d;
      free_q   <= free_d;
      cnt_q    <= act_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
      end
      active_q  <= '0;
      act_cnt_q <= '0;
      pool_q    <= '0;
    end else if (cmd_i.exec) begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      active_q  <= active_d;
      act_cnt_q <= act_cnt_d;
      pool_q    <= pool_d;
    end
  end

  always_comb begin
    conn_on = (int'(conn_q) < CONNECTIONS) && active_q[conn_q];
    rp      = rd_ptr_q[conn_q];
    wp      = wr_ptr_q[conn_q];
    rp_nx   = (int'(rp) == QUEUE_DEPTH - 1) ? '0 : rp + PTR_W'(1);
    wp_nx   = (int'(wp) == QUEUE_DEPTH - 1) ? '0 : wp + PTR_W'(1);
    waddr   = {conn_q, wp};

    pool_slot = '0;
    pool_hit  = 1'b0;
    for (int s = POOL_BUFFERS - 1; s >= 0; s--) begin
      if (!pool_q[s]) begin
        pool_slot = POOL_W'(s);
        pool_hit  = 1'b1;
      end
    end

    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    active_d  = active_q;
    act_cnt_d = act_cnt_q;
    pool_d    = pool_q;
    status_d  = ST_OK;
    alloc_d   = '0;
    iw_d      = 1'b0;
    iv_d      = 1'b0;
    we        = 1'b0;

    case (act_q)
      ACT_OPEN: begin
        if (int'(conn_q) < CONNECTIONS && !active_q[conn_q]) begin
          rd_ptr_d[conn_q] = '0;
          wr_ptr_d[conn_q] = '0;
          active_d[conn_q] = 1'b1;
          act_cnt_d        = act_cnt_q + CNT_W'(1);
        end else begin
          status_d = ST_BAD_CONN;
        end
      end
      ACT_CLOSE: begin
        if (conn_on) begin
          active_d[conn_q] = 1'b0;
          act_cnt_d        = act_cnt_q - CNT_W'(1);
        end else begin
          status_d = ST_BAD_CONN;
        end
      end
      ACT_ENQ: begin
        if (!conn_on) begin
          status_d = ST_BAD_CONN;
        end else if (hdl_q == '0) begin
          status_d = ST_NULL;
        end else if (wp_nx == rp) begin
          status_d = ST_FULL;
        end else begin
          we               = cmd_i.exec;
          wr_ptr_d[conn_q] = wp_nx;
          iw_d             = 1'b1;
          iv_d             = 1'b1;
        end
      end
      ACT_DEQ: begin
        if (!conn_on) begin
          status_d = ST_BAD_CONN;
        end else if (rp == wp) begin
          status_d = ST_EMPTY;
          iw_d     = 1'b1;
        end else begin
          rd_ptr_d[conn_q] = rp_nx;
          if (rdata != '0 && rdata <= HANDLE_W'(POOL_BUFFERS)) begin
            pool_d[POOL_W'(rdata - HANDLE_W'(1))] = 1'b0;
          end else begin
            status_d = ST_FREED_NONE;
          end
        end
      end
      ACT_ALLOC: begin
        if (pool_hit) begin
          pool_d[pool_slot] = 1'b1;
          alloc_d           = ALLOC_W'(pool_slot) + ALLOC_W'(1);
        end else begin
          status_d = ST_POOL_OUT;
        end
      end
      default: begin
        status_d = ST_BAD_CONN;
      end
    endcase

    free_d = CNT_W'(CONNECTIONS);
    for (int c = CONNECTIONS - 1; c >= 0; c--) begin
      if (!active_d[c]) begin
        free_d = CNT_W'(c);
      end
    end
  end

  assign status_o          = status_q;
  assign alloc_handle_o    = alloc_q;
  assign indicator_write_o = iw_q;
  assign indicator_value_o = iv_q;
  assign free_instance_o   = free_q;
  assign active_count_o    = cnt_q;

  `ASSERT_IMPL(a_cnt_match, 1'b1, int'(act_cnt_q) == $countones(active_q), "active count drift")
  `ASSERT_NEXT(a_enq_ptr, cmd_i.exec && we, wr_ptr_q[$past(conn_q)] == $past(wp_nx), "enqueue pointer not advanced")

endmodule

>>> rtl/core/multi_instance_buffer_queue_manager.sv
// ----------------------------------------------------------------------------
// multi_instance_buffer_queue_manager
// Per-connection ring queues of buffer handles with a shared buffer pool.
//
// channel  | direction | handshake
// command  | in        | start & !busy accepts action, instance_req, handle
// result   | out       | done_o marks one cycle of status .. active_count
//
// An item is accepted in S_IDLE, and the accept reads the queue store at the
// addressed read pointer; S_EXEC then updates pointers, flags and
// pool and registers the result, which shows on the next cycle with done_o.
// The next item may be accepted in that same result cycle, but not while
// busy is high in S_EXEC, as the registered read of the queue store comes first.
// Reset clears pointers, flags and pool at once; the store needs no clearing.
// The receiver cannot stall; nothing is held back on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_instance_buffer_queue_manager
  import mibqm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          action_i,
  input  logic [CONN_W-1:0]   instance_req_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [ALLOC_W-1:0]  alloc_handle_o,
  output logic                indicator_write_o,
  output logic                indicator_value_o,
  output logic [CNT_W-1:0]    free_instance_o,
  output logic [CNT_W-1:0]    active_count_o
);

  dp_cmd_t cmd;

  mibqm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  mibqm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .instance_req_i   (instance_req_i),
    .handle_i         (handle_i),
    .status_o         (status_o),
    .alloc_handle_o   (alloc_handle_o),
    .indicator_write_o(indicator_write_o),
    .indicator_value_o(indicator_value_o),
    .free_instance_o  (free_instance_o),
    .active_count_o   (active_count_o)
  );

endmodule
